// ===== rtl/kgsr_pkg.sv =====
// Package for the k-group sequence reverser: widths, depth and cell control type.
package kgsr_pkg;

  // Cells in the reversal chain (largest group)
  localparam int GROUP_DEPTH = 16;
  // Field widths
  localparam int ELEM_W = 32;
  localparam int SIZE_W = 5;
  // Fill count holds 0..GROUP_DEPTH
  localparam int CNT_W = $clog2(GROUP_DEPTH + 1);
  // Width used to compare the fill count with the group size
  localparam int CMP_W = (SIZE_W > CNT_W) ? SIZE_W : CNT_W;

  // Shift control shared by every cell of the chain
  typedef struct packed {
    logic push;  // shift toward the tail, head takes the new word
    logic pop;   // shift toward the head, head word leaves
  } kgsr_ctrl_t;

endpackage

// ===== rtl/kgsr_cell.sv =====
// One cell of the LIFO chain: holds one element, shifts with its neighbors.
module kgsr_cell
  import kgsr_pkg::*;
(
  input  logic              clk_i,
  input  kgsr_ctrl_t        ctrl_i,
  input  logic [ELEM_W-1:0] head_side_i,  // from the neighbor nearer the head
  input  logic [ELEM_W-1:0] tail_side_i,  // from the neighbor nearer the tail
  output logic [ELEM_W-1:0] data_o
);

  logic [ELEM_W-1:0] data_q;

  // Payload only: no reset needed
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      data_q <= head_side_i;
    end else if (ctrl_i.pop) begin
      data_q <= tail_side_i;
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/k_group_sequence_reverser.sv =====
// Top level of the k-group sequence reverser: control, cell chain and output register.
// Each accepted word is pushed onto the chain head. A group of n words then
// drains with one pop from the chain head per cycle while the output is not stalled,
// and the input is held off meanwhile. Pass-through (group size 0 or 1) thus
// alternates an accepted word and its drain. Each pop loads the output register.
// Reset (rst_ni low, asynchronous) clears fill count, drain state, output valid and
// sets group_size to 1; the cell contents are left undefined until written.
module k_group_sequence_reverser
  import kgsr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,    // group_size
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ELEM_W-1:0] s_axis_tdata,   // [31:0] element
  input  logic              s_axis_tlast,   // list_end
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [ELEM_W-1:0] m_axis_tdata,   // [31:0] out_element
  output logic              m_axis_tlast,   // group_last
  output logic              m_axis_tuser    // [0] list_last
);

  logic [SIZE_W-1:0] size_q;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic              drain_q, drain_d;
  logic              lend_q, lend_d;
  logic              ovld_q, ovld_d;
  logic [ELEM_W-1:0] odata_q;
  logic              oglast_q, olast_q;

  logic              accept, pop;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CMP_W-1:0]  size_ext, k_eff;
  logic              close;
  kgsr_ctrl_t        ctrl;
  logic [ELEM_W-1:0] cell_data [GROUP_DEPTH];

  assign s_axis_tready = !drain_q;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign pop    = drain_q && (!ovld_q || m_axis_tready);

  assign ctrl.push = accept;
  assign ctrl.pop  = pop;

  // Effective group size, clamped to 1..GROUP_DEPTH
  always_comb begin
    size_ext = CMP_W'(size_q);
    if (size_ext > CMP_W'(GROUP_DEPTH)) begin
      k_eff = CMP_W'(GROUP_DEPTH);
    end else if (size_ext == '0) begin
      k_eff = CMP_W'(1);
    end else begin
      k_eff = size_ext;
    end
  end

  // Fill count never reaches the depth while accepting, so no overflow here
  assign cnt_inc = fill_q + CNT_W'(1);
  assign close   = (CMP_W'(cnt_inc) >= k_eff) || s_axis_tlast;

  // Fill / drain control
  always_comb begin
    fill_d  = fill_q;
    rem_d   = rem_q;
    drain_d = drain_q;
    lend_d  = lend_q;
    if (accept) begin
      if (close) begin
        fill_d  = '0;
        rem_d   = cnt_inc;
        drain_d = 1'b1;
        lend_d  = s_axis_tlast;
      end else begin
        fill_d = cnt_inc;
      end
    end
    if (pop) begin
      rem_d = rem_q - CNT_W'(1);
      if (rem_q == CNT_W'(1)) begin
        drain_d = 1'b0;
      end
    end
  end

  // Output valid: load on pop, clear when taken
  always_comb begin
    ovld_d = ovld_q;
    if (pop) begin
      ovld_d = 1'b1;
    end else if (m_axis_tready) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SIZE_W'(1);
      fill_q  <= '0;
      rem_q   <= '0;
      drain_q <= 1'b0;
      lend_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      fill_q  <= fill_d;
      rem_q   <= rem_d;
      drain_q <= drain_d;
      lend_q  <= lend_d;
      ovld_q  <= ovld_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (pop) begin
      odata_q  <= cell_data[0];
      oglast_q <= (rem_q == CNT_W'(1));
      olast_q  <= (rem_q == CNT_W'(1)) && lend_q;
    end
  end

  // Cell chain: head (cell 0) holds the newest word
  for (genvar i = 0; i < GROUP_DEPTH; i++) begin : g_cell
    logic [ELEM_W-1:0] head_side, tail_side;
    if (i == 0) begin : g_head
      assign head_side = s_axis_tdata;
    end else begin : g_mid
      assign head_side = cell_data[i-1];
    end
    if (i == GROUP_DEPTH - 1) begin : g_tail
      assign tail_side = '0;
    end else begin : g_body
      assign tail_side = cell_data[i+1];
    end
    kgsr_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .head_side_i (head_side),
      .tail_side_i (tail_side),
      .data_o      (cell_data[i])
    );
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = oglast_q;
  assign m_axis_tuser  = olast_q;

endmodule

// ===== rtl/kgsr_checker.sv =====
// Port-level checker for the k-group sequence reverser, bound to the top level.
module kgsr_checker
  import kgsr_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              s_axis_tlast,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [ELEM_W-1:0] m_axis_tdata,
  input logic              m_axis_tlast,
  input logic              m_axis_tuser
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("stalled output word changed");

  // List end only closes a group
  a_list_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("list_last without group_last");

  // A list end always closes the group, so input stalls for the drain
  a_drain_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input ready right after list end");

  // Results come only from a drain, which follows an accepted word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !s_axis_tready || $past(!s_axis_tready))
    else $error("result word without a closed group");

endmodule

bind k_group_sequence_reverser kgsr_checker u_kgsr_checker (.*);

// ===== sim/tb_k_group_sequence_reverser.sv =====
// Testbench for k_group_sequence_reverser: random-gap stream driver, self-checking monitor.
`timescale 1ns / 100ps

module tb_k_group_sequence_reverser;
  import kgsr_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int STALL_LIMIT    = 2000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES  = 40;
  localparam int SQUEEZE_CYCLES = 150;
  localparam int GAP_PERCENT    = 29;
  localparam int PHASE_WORDS    = 22;
  localparam int NUM_PHASES     = 11;

  localparam logic [ELEM_W-1:0] ELEM_MIN = 32'h8000_0000;
  localparam logic [ELEM_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              list_end;
  } list_word_t;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              group_last;
    logic              list_last;
  } rev_word_t;

  // DUT signals, all inputs known from time zero
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [ELEM_W-1:0] s_axis_tdata  = '0;  // [31:0] element
  logic              s_axis_tlast  = 1'b0; // list_end
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [ELEM_W-1:0] m_axis_tdata;         // [31:0] out_element
  logic              m_axis_tlast;         // group_last
  logic              m_axis_tuser;         // [0] list_last

  // stimulus and scoreboard
  list_word_t  list_words[$];
  rev_word_t   reversed_words[$];
  int unsigned words_queued = 0;
  int unsigned words_taken  = 0;
  int unsigned fail_cnt     = 0;
  int unsigned quiet_cycles = 0;
  logic        calm         = 1'b0;
  logic        squeeze      = 1'b0;

  // predictor state
  logic [ELEM_W-1:0] grp_store [GROUP_DEPTH];
  int unsigned       grp_fill = 0;
  logic [SIZE_W-1:0] grp_size = SIZE_W'(1);

  // receiver hold-off, owned by the sink process
  int unsigned hold_left = 0;
  logic        squeezed  = 1'b0;

  k_group_sequence_reverser DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // group size after clamping to 1..GROUP_DEPTH
  function automatic int unsigned clamp_size(logic [SIZE_W-1:0] sz);
    if (sz > GROUP_DEPTH) return GROUP_DEPTH;
    if (sz < 1) return 1;
    return 32'(sz);
  endfunction

  // store one word; on a full group or list end, expect the group newest first
  function automatic void push_and_reverse(list_word_t w);
    int unsigned k;
    int          i;
    rev_word_t   r;
    k = clamp_size(grp_size);
    if (grp_fill < GROUP_DEPTH) begin
      grp_store[grp_fill] = w.element;
      grp_fill++;
    end
    if (grp_fill < k && !w.list_end) return;
    for (i = int'(grp_fill) - 1; i >= 0; i--) begin
      r.element    = grp_store[i];
      r.group_last = (i == 0);
      r.list_last  = (i == 0) && w.list_end;
      reversed_words.push_back(r);
    end
    grp_fill = 0;
  endfunction

  function automatic logic take_gap();
    return !calm && ($urandom_range(99) < GAP_PERCENT);
  endfunction

  // mostly random, sometimes an extreme
  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(15))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_word(logic [ELEM_W-1:0] elem, logic last);
    list_words.push_back('{element: elem, list_end: last});
    words_queued++;
  endtask

  task automatic write_size(logic [SIZE_W-1:0] sz);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sz;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // wait for all words taken and all results seen, then let the block settle
  task automatic drain_all();
    while (words_taken != words_queued) @(posedge clk_i);
    while (reversed_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // input driver
  always @(posedge clk_i) begin
    list_word_t w;
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (list_words.size() != 0 && !take_gap()) begin
        w = list_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w.element;
        s_axis_tlast  <= w.list_end;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output ready, with one long hold-off when asked
  always @(posedge clk_i) begin
    if (squeeze && !squeezed) begin
      squeezed  = 1'b1;
      hold_left = SQUEEZE_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= GAP_PERCENT);
    end
  end

  // monitor: track config, predict on input, check on output
  always @(posedge clk_i) begin
    rev_word_t want;
    if (rst_ni) begin
      if (cfg_we_i) grp_size = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        if (reversed_words.size() == 0) begin
          $error("unexpected word: out_element %h", m_axis_tdata);
          fail_cnt++;
        end else begin
          want = reversed_words.pop_front();
          if (m_axis_tdata !== want.element) begin
            $error("out_element: expected %h, got %h", want.element, m_axis_tdata);
            fail_cnt++;
          end
          if (m_axis_tlast !== want.group_last) begin
            $error("group_last: expected %b, got %b", want.group_last, m_axis_tlast);
            fail_cnt++;
          end
          if (m_axis_tuser !== want.list_last) begin
            $error("list_last: expected %b, got %b", want.list_last, m_axis_tuser);
            fail_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        push_and_reverse('{element: s_axis_tdata, list_end: s_axis_tlast});
        words_taken++;
      end
    end
  end

  // watchdog on traffic
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    int          sizes [NUM_PHASES];
    int unsigned k;
    int unsigned len;
    int unsigned n;
    int unsigned j;
    sizes = '{16, 31, 2, 1, 7, 0, 17, 5, 3, 12, 16};
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset size of one: extremes pass straight through
    queue_word(ELEM_MIN, 1'b0);
    queue_word(ELEM_MAX, 1'b1);
    drain_all();
    // size zero also passes through
    write_size(SIZE_W'(0));
    queue_word('1, 1'b0);
    queue_word('0, 1'b1);
    drain_all();
    // full group, short group closed by list end, lone list end
    write_size(SIZE_W'(3));
    queue_word(32'd1, 1'b0);
    queue_word(32'd2, 1'b0);
    queue_word(32'd3, 1'b0);
    queue_word(32'd4, 1'b0);
    queue_word(32'd5, 1'b1);
    queue_word(32'd6, 1'b1);
    drain_all();
    // size lowered while two words wait: third word flushes all three
    write_size(SIZE_W'(4));
    queue_word(32'hA0A0_A0A0, 1'b0);
    queue_word(32'hB1B1_B1B1, 1'b0);
    drain_all();
    write_size(SIZE_W'(2));
    queue_word(32'hC2C2_C2C2, 1'b0);
    drain_all();
    // size dropped to pass-through with words pending
    write_size(SIZE_W'(5));
    queue_word(32'hD3D3_D3D3, 1'b0);
    queue_word(32'hE4E4_E4E4, 1'b0);
    drain_all();
    write_size(SIZE_W'(0));
    queue_word(32'hF5F5_F5F5, 1'b1);
    drain_all();

    // random lists, one phase per group size
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_size(SIZE_W'(sizes[ph]));
      calm    <= (ph == 3) || (ph == 9);
      squeeze <= squeeze || (ph == 4);
      k = clamp_size(SIZE_W'(sizes[ph]));
      n = 0;
      while (n < PHASE_WORDS) begin
        len = $urandom_range(1, 2 * k + 2);
        for (j = 0; j < len; j++) queue_word(rand_elem(), j == len - 1);
        n += len;
      end
      // sometimes leave a partial group for the next size to pick up
      if (k > 1 && ph != NUM_PHASES - 1 && $urandom_range(3) == 0) begin
        len = $urandom_range(1, k - 1);
        for (j = 0; j < len; j++) queue_word(rand_elem(), 1'b0);
      end
      drain_all();
    end

    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
